// ===== src/chs_pkg.sv =====
// Shared constants, codes and types of the chapter heading scanner.
package chs_pkg;

   localparam int MAX_LINE_BYTES = 60;
   localparam int TITLE_CHARS    = 20;
   localparam int MAX_ENTRIES    = 30;
   localparam int TITLE_BYTES    = 64;
   localparam int STORE_DEPTH    = MAX_LINE_BYTES + 4;
   localparam int LEN_TOO_LONG   = STORE_DEPTH + 1;

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int LEN_W   = $clog2(LEN_TOO_LONG + 1);
   localparam int CHARS_W = $clog2(TITLE_CHARS + 1);

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 72;
   localparam int SKIP_W     = 16;
   localparam int COUNT_W    = 16;
   localparam int POS_W      = 32;
   localparam int SLOT_W     = 5;

   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_DIGIT_0 = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9 = 8'h39;
   localparam logic [7:0] BYTE_LEAD3   = 8'hE0;
   localparam logic [7:0] BYTE_E7      = 8'hE7;
   localparam logic [7:0] BYTE_AC      = 8'hAC;
   localparam logic [7:0] BYTE_AB      = 8'hAB;
   localparam logic [7:0] BYTE_A0      = 8'hA0;
   localparam logic [7:0] BOM_0        = 8'hEF;
   localparam logic [7:0] BOM_1        = 8'hBB;
   localparam logic [7:0] BOM_2        = 8'hBF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HDR0,
      ST_HDR1,
      ST_HDR2,
      ST_HDR3,
      ST_HDR4,
      ST_CAND,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_DIG,
      ST_E1,
      ST_E2,
      ST_TREAD,
      ST_TLOAD
   } state_type;

endpackage

// ===== src/chapter_heading_scanner.sv =====
// Chapter heading scanner: line splitting, heading match and title output over one line memory.
// A byte that does not close a line leaves the scanner idle. A closing byte starts the header
// reads (HDR0 to HDR4), then a pattern scan over the line bytes, then a read and a load state
// per title byte, all through the single read port of the line memory. No new byte is taken
// until the pass ends; the last title byte may still wait in the output register. Synchronous
// reset, active high, clears counters, position and the output valid flag and sets the BOM flag.
module chapter_heading_scanner (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [chs_pkg::SKIP_W-1:0]     csr_wdata,   // skip_count
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [chs_pkg::REQ_DATA_W-1:0] req_tdata,   // data_byte
   input  logic                           req_tuser,   // new_file
   input  logic                           req_tlast,   // end_of_file
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // chapter_number[15:0], line_offset[47:16], slot[52:48], title_byte[60:53],
   // stored_count[65:61], zero fill[71:66]
   output logic [chs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast    // last_of_title
);
   import chs_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data_ff;

   state_type state_ff, state_in;
   logic [SKIP_W-1:0]  skip_count_ff, skip_count_in;
   logic [LEN_W-1:0]   line_length_ff, line_length_in;
   logic [POS_W-1:0]   line_start_ff, line_start_in;
   logic [POS_W-1:0]   byte_position_ff, byte_position_in;
   logic [COUNT_W-1:0] heading_count_ff, heading_count_in;
   logic [SLOT_W-1:0]  saved_count_ff, saved_count_in;
   logic               bom_pending_ff, bom_pending_in;
   logic [LEN_W-1:0]   raw_ff, raw_in;
   logic [2:0]         hdr_ff, hdr_in;
   logic               strip_ff, strip_in;
   logic [LEN_W-1:0]   n_ff, n_in;
   logic [LEN_W-1:0]   i_ff, i_in;
   logic [LEN_W-1:0]   p_ff, p_in;
   logic               dig_first_ff, dig_first_in;
   logic [LEN_W-1:0]   j_ff, j_in;
   logic [LEN_W-1:0]   bound_ff, bound_in;
   logic [CHARS_W-1:0] chars_ff, chars_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   logic [LEN_W-1:0]   base;
   logic [LEN_W-1:0]   eff_len;
   logic [LEN_W-1:0]   e_len;
   logic [LEN_W-1:0]   len_inc;
   logic [LEN_W-1:0]   n_calc;
   logic [LEN_W-1:0]   bound_next;
   logic [CHARS_W-1:0] chars_next;
   logic [POS_W-1:0]   pos_eff;
   logic [SLOT_W-1:0]  saved_eff;
   logic               is_digit;
   logic               is_lead3;
   logic               strip_calc;
   logic               title_last;
   logic               out_free;
   logic [COUNT_W-1:0] count_sat;

   assign base       = strip_ff ? LEN_W'(3) : LEN_W'(0);
   assign is_digit   = (rd_data_ff >= BYTE_DIGIT_0) && (rd_data_ff <= BYTE_DIGIT_9);
   assign is_lead3   = rd_data_ff >= BYTE_LEAD3;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign count_sat  = (heading_count_ff != '1) ? heading_count_ff + 1'b1 : heading_count_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         skip_count_ff    <= '0;
         line_length_ff   <= '0;
         line_start_ff    <= '0;
         byte_position_ff <= '0;
         heading_count_ff <= '0;
         saved_count_ff   <= '0;
         bom_pending_ff   <= 1'b1;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         state_ff         <= state_in;
         skip_count_ff    <= skip_count_in;
         line_length_ff   <= line_length_in;
         line_start_ff    <= line_start_in;
         byte_position_ff <= byte_position_in;
         heading_count_ff <= heading_count_in;
         saved_count_ff   <= saved_count_in;
         bom_pending_ff   <= bom_pending_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
      raw_ff       <= raw_in;
      hdr_ff       <= hdr_in;
      strip_ff     <= strip_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      p_ff         <= p_in;
      dig_first_ff <= dig_first_in;
      j_ff         <= j_in;
      bound_ff     <= bound_in;
      chars_ff     <= chars_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   always_comb begin
      state_in         = state_ff;
      skip_count_in    = csr_we ? csr_wdata : skip_count_ff;
      line_length_in   = line_length_ff;
      line_start_in    = line_start_ff;
      byte_position_in = byte_position_ff;
      heading_count_in = heading_count_ff;
      saved_count_in   = saved_count_ff;
      bom_pending_in   = bom_pending_ff;
      raw_in           = raw_ff;
      hdr_in           = hdr_ff;
      strip_in         = strip_ff;
      n_in             = n_ff;
      i_in             = i_ff;
      p_in             = p_ff;
      dig_first_in     = dig_first_ff;
      j_in             = j_ff;
      bound_in         = bound_ff;
      chars_in         = chars_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in     = rsp_tdata_ff;
      rsp_tlast_in     = rsp_tlast_ff;
      mem_we           = 1'b0;
      mem_waddr        = ADDR_W'(line_length_ff);
      rd_addr          = '0;

      eff_len    = req_tuser ? '0 : line_length_ff;
      pos_eff    = req_tuser ? '0 : byte_position_ff;
      saved_eff  = req_tuser ? '0 : saved_count_ff;
      len_inc    = (eff_len < LEN_W'(LEN_TOO_LONG)) ? eff_len + 1'b1 : eff_len;
      e_len      = raw_ff - ((rd_data_ff == BYTE_CR) ? LEN_W'(1) : LEN_W'(0));
      strip_calc = bom_pending_ff && (e_len >= LEN_W'(3)) && (hdr_ff == 3'b111);
      n_calc     = e_len - (strip_calc ? LEN_W'(3) : LEN_W'(0));

      if (j_ff == bound_ff) begin
         chars_next = chars_ff + 1'b1;
         bound_next = j_ff + (is_lead3 ? LEN_W'(3) : LEN_W'(1));
      end else begin
         chars_next = chars_ff;
         bound_next = bound_ff;
      end
      title_last = (j_ff + 1'b1 == n_ff)
                || ((j_ff + 1'b1 == bound_next) && (chars_next == CHARS_W'(TITLE_CHARS)))
                || (j_ff + 1'b1 == LEN_W'(TITLE_BYTES - 1));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  line_length_in   = '0;
                  line_start_in    = '0;
                  byte_position_in = '0;
                  heading_count_in = '0;
                  saved_count_in   = '0;
                  bom_pending_in   = 1'b1;
               end
               if (saved_eff < SLOT_W'(MAX_ENTRIES)) begin
                  if (eff_len == '0) begin
                     line_start_in = pos_eff;
                  end
                  byte_position_in = pos_eff + 1'b1;
                  if (req_tdata == BYTE_LF) begin
                     raw_in         = eff_len;
                     line_length_in = '0;
                     state_in       = (eff_len == '0) ? ST_IDLE : ST_HDR0;
                  end else begin
                     mem_we    = eff_len < LEN_W'(STORE_DEPTH);
                     mem_waddr = ADDR_W'(eff_len);
                     if (req_tlast) begin
                        raw_in         = len_inc;
                        line_length_in = '0;
                        state_in       = ST_HDR0;
                     end else begin
                        line_length_in = len_inc;
                     end
                  end
               end
            end
         end
         ST_HDR0: begin
            rd_addr  = ADDR_W'(0);
            state_in = ST_HDR1;
         end
         ST_HDR1: begin
            rd_addr   = ADDR_W'(1);
            hdr_in[0] = rd_data_ff == BOM_0;
            state_in  = ST_HDR2;
         end
         ST_HDR2: begin
            rd_addr   = ADDR_W'(2);
            hdr_in[1] = rd_data_ff == BOM_1;
            state_in  = ST_HDR3;
         end
         ST_HDR3: begin
            rd_addr   = ADDR_W'(raw_ff - 1'b1);
            hdr_in[2] = rd_data_ff == BOM_2;
            state_in  = ST_HDR4;
         end
         ST_HDR4: begin
            state_in = ST_IDLE;
            if (raw_ff >= LEN_W'(LEN_TOO_LONG)) begin
               if (bom_pending_ff && (hdr_ff == 3'b111)) begin
                  bom_pending_in = 1'b0;
               end
            end else begin
               if (strip_calc) begin
                  bom_pending_in = 1'b0;
               end
               strip_in = strip_calc;
               n_in     = n_calc;
               i_in     = '0;
               if ((n_calc != '0) && (n_calc <= LEN_W'(MAX_LINE_BYTES))) begin
                  state_in = ST_CAND;
               end
            end
         end
         ST_CAND: begin
            rd_addr = ADDR_W'(base + i_ff);
            if ({1'b0, i_ff} + (LEN_W + 1)'(6) < {1'b0, n_ff}) begin
               state_in = ST_M0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_M0: begin
            rd_addr = ADDR_W'(base + i_ff + LEN_W'(1));
            if (rd_data_ff == BYTE_E7) begin
               state_in = ST_M1;
            end else begin
               i_in     = i_ff + (is_lead3 ? LEN_W'(3) : LEN_W'(1));
               state_in = ST_CAND;
            end
         end
         ST_M1: begin
            rd_addr = ADDR_W'(base + i_ff + LEN_W'(2));
            if (rd_data_ff == BYTE_AC) begin
               state_in = ST_M2;
            end else begin
               i_in     = i_ff + LEN_W'(3);
               state_in = ST_CAND;
            end
         end
         ST_M2: begin
            rd_addr = ADDR_W'(base + i_ff + LEN_W'(3));
            if (rd_data_ff == BYTE_AC) begin
               p_in         = i_ff + LEN_W'(3);
               dig_first_in = 1'b1;
               state_in     = ST_DIG;
            end else begin
               i_in     = i_ff + LEN_W'(3);
               state_in = ST_CAND;
            end
         end
         ST_DIG: begin
            rd_addr  = ADDR_W'(base + p_ff + LEN_W'(1));
            i_in     = i_ff + LEN_W'(3);
            state_in = ST_CAND;
            if (is_digit) begin
               if (p_ff + LEN_W'(1) < n_ff) begin
                  p_in         = p_ff + LEN_W'(1);
                  dig_first_in = 1'b0;
                  i_in         = i_ff;
                  state_in     = ST_DIG;
               end
            end else if (!dig_first_ff && (rd_data_ff == BYTE_E7)
                         && (p_ff + LEN_W'(2) < n_ff)) begin
               i_in     = i_ff;
               state_in = ST_E1;
            end
         end
         ST_E1: begin
            rd_addr = ADDR_W'(base + p_ff + LEN_W'(2));
            if (rd_data_ff == BYTE_AB) begin
               state_in = ST_E2;
            end else begin
               i_in     = i_ff + LEN_W'(3);
               state_in = ST_CAND;
            end
         end
         ST_E2: begin
            if (rd_data_ff != BYTE_A0) begin
               i_in     = i_ff + LEN_W'(3);
               state_in = ST_CAND;
            end else if (heading_count_ff >= skip_count_ff) begin
               j_in     = '0;
               bound_in = '0;
               chars_in = '0;
               state_in = ST_TREAD;
            end else begin
               heading_count_in = count_sat;
               state_in         = ST_IDLE;
            end
         end
         ST_TREAD: begin
            rd_addr  = ADDR_W'(base + j_ff);
            state_in = ST_TLOAD;
         end
         ST_TLOAD: begin
            rd_addr = ADDR_W'(base + j_ff);
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'b0, saved_count_ff + 1'b1, rd_data_ff, saved_count_ff,
                                line_start_ff, heading_count_ff};
               rsp_tlast_in  = title_last;
               if (title_last) begin
                  saved_count_in   = saved_count_ff + 1'b1;
                  heading_count_in = count_sat;
                  state_in         = ST_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  bound_in = bound_next;
                  chars_in = chars_next;
                  state_in = ST_TREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/sv/chapter_heading_scanner_tb.sv =====
// Self-checking testbench for the chapter heading scanner with a built-in predictor.
module chapter_heading_scanner_tb;
   import chs_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int DRAIN       = 300;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int HOLD_CYCLES = 500;

   typedef logic [7:0] byte_list_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       starts_file;
      logic       ends_file;
   } file_byte_type;

   typedef struct {
      logic [COUNT_W-1:0] chapter;
      logic [POS_W-1:0]   offset;
      logic [SLOT_W-1:0]  slot;
      logic [7:0]         glyph;
      logic               closing;
      logic [SLOT_W-1:0]  stored;
   } title_beat_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_we = 0;
   logic [SKIP_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  req_tlast = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   chapter_heading_scanner dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // Predictor state.
   logic [7:0]        line_mem [STORE_DEPTH];
   int                line_len = 0;
   logic [POS_W-1:0]  line_begin = '0;
   logic [POS_W-1:0]  file_pos = '0;
   int                heading_idx = 0;
   int                stored_n = 0;
   bit                bom_wait = 1;
   logic [SKIP_W-1:0] skip_cfg = '0;

   title_beat_type title_q[$];
   file_byte_type  byte_q[$];
   int             queued_n = 0;
   int             taken_n = 0;
   int             fail_n = 0;
   int             cycle_n = 0;
   bit             req_done = 0;
   int             send_gap = 0;
   int             ready_gap = 0;
   int             hold_left = 0;
   bit             held = 0;
   bit             steady = 0;
   file_byte_type  next_byte;

   initial forever #CLOCK_HALF clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic bit bom_at_front();
      return line_mem[0] == BOM_0 && line_mem[1] == BOM_1 && line_mem[2] == BOM_2;
   endfunction

   function automatic bit heading_mark(input int s, input int n);
      int i;
      int p;
      i = 0;
      while (i < n - 6) begin
         if (line_mem[s+i] == BYTE_E7 && line_mem[s+i+1] == BYTE_AC
               && line_mem[s+i+2] == BYTE_AC) begin
            p = i + 3;
            if (p < n && line_mem[s+p] inside {[BYTE_DIGIT_0:BYTE_DIGIT_9]}) begin
               while (p < n && line_mem[s+p] inside {[BYTE_DIGIT_0:BYTE_DIGIT_9]}) p++;
               if (p + 2 < n && line_mem[s+p] == BYTE_E7 && line_mem[s+p+1] == BYTE_AB
                     && line_mem[s+p+2] == BYTE_A0) return 1;
            end
         end
         i += (line_mem[s+i] >= BYTE_LEAD3) ? 3 : 1;
      end
      return 0;
   endfunction

   task automatic finish_line();
      int             raw;
      int             s;
      int             e;
      int             n;
      int             i;
      int             chars;
      byte_list_type  title;
      title_beat_type beat;
      raw = line_len;
      line_len = 0;
      s = 0;
      if (raw >= LEN_TOO_LONG) begin
         if (bom_wait && bom_at_front()) bom_wait = 0;
         return;
      end
      e = raw;
      if (e > 0 && line_mem[e-1] == BYTE_CR) e--;
      if (bom_wait && e >= 3 && bom_at_front()) begin
         s = 3;
         bom_wait = 0;
      end
      n = e - s;
      if (n < 1 || n > MAX_LINE_BYTES || !heading_mark(s, n)) return;
      if (heading_idx >= skip_cfg) begin
         i = 0;
         chars = 0;
         while (i < n && chars < TITLE_CHARS) begin
            title = {title, line_mem[s+i]};
            if (line_mem[s+i] >= BYTE_LEAD3) begin
               if (i + 1 < n) title = {title, line_mem[s+i+1]};
               if (i + 2 < n) title = {title, line_mem[s+i+2]};
               i += 3;
            end else begin
               i += 1;
            end
            chars++;
         end
         if (title.size() > TITLE_BYTES - 1) title = title[0:TITLE_BYTES-2];
         foreach (title[k]) begin
            beat.chapter = heading_idx[COUNT_W-1:0];
            beat.offset  = line_begin;
            beat.slot    = stored_n[SLOT_W-1:0];
            beat.glyph   = title[k];
            beat.closing = (k == title.size() - 1);
            beat.stored  = SLOT_W'(stored_n + 1);
            title_q = {title_q, beat};
         end
         stored_n++;
      end
      if (heading_idx < 16'hFFFF) heading_idx++;
   endtask

   task automatic take_byte(input logic [7:0] b, input logic nf, input logic eof);
      if (nf) begin
         line_len = 0;
         line_begin = '0;
         file_pos = '0;
         heading_idx = 0;
         stored_n = 0;
         bom_wait = 1;
      end
      if (stored_n >= MAX_ENTRIES) return;
      if (line_len == 0) line_begin = file_pos;
      file_pos++;
      if (b == BYTE_LF) begin
         finish_line();
         return;
      end
      if (line_len < STORE_DEPTH) line_mem[line_len] = b;
      if (line_len < LEN_TOO_LONG) line_len++;
      if (eof) finish_line();
   endtask

   task automatic put_seq(input byte_list_type seq, input bit nf, input bit eof);
      file_byte_type fb;
      foreach (seq[k]) begin
         fb.data = seq[k];
         fb.starts_file = nf && (k == 0);
         fb.ends_file = eof && (k == seq.size() - 1);
         byte_q = {byte_q, fb};
         queued_n++;
      end
   endtask

   task automatic add_char(ref byte_list_type body);
      int r;
      logic [7:0] b;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         body = {body, 8'($urandom_range(8'h20, 8'h7E))};
      end else if (r < 90) begin
         body = {body, 8'($urandom_range(8'hE0, 8'hEF))};
         body = {body, 8'($urandom_range(8'h80, 8'hBF))};
         body = {body, 8'($urandom_range(8'h80, 8'hBF))};
      end else begin
         b = 8'($urandom_range(0, 255));
         body = {body, (b == BYTE_LF) ? 8'h0B : b};
      end
   endtask

   task automatic add_heading(ref byte_list_type body, input bit broken, input int tail_max);
      int flaw;
      int mark;
      int digits;
      flaw = broken ? $urandom_range(0, 3) : -1;
      repeat ($urandom_range(0, 2)) add_char(body);
      if (flaw == 2) body = {body, 8'($urandom_range(8'hE0, 8'hFF))};
      mark = body.size();
      body = {body, BYTE_E7, BYTE_AC, BYTE_AC};
      digits = (flaw == 1) ? 0 : $urandom_range(1, 4);
      repeat (digits) body = {body, 8'($urandom_range(BYTE_DIGIT_0, BYTE_DIGIT_9))};
      if (flaw == 3) body = {body, ($urandom_range(0, 1) != 0) ? 8'h2F : 8'h3A};
      body = {body, BYTE_E7, BYTE_AB, BYTE_A0};
      if (flaw == 0) body[mark + $urandom_range(0, 2)] ^= 8'h01 << $urandom_range(0, 7);
      repeat ($urandom_range(0, tail_max)) add_char(body);
   endtask

   task automatic put_random_line();
      byte_list_type body;
      int kind;
      int target;
      int ending;
      bit nf;
      bit eof;
      kind = $urandom_range(0, 99);
      nf = ($urandom_range(0, 19) == 0);
      eof = 0;
      if (kind < 60) begin
         add_heading(body, 0, 22);
      end else if (kind < 75) begin
         add_heading(body, 1, 10);
      end else if (kind < 88) begin
         repeat ($urandom_range(0, 20)) body = {body, 8'($urandom_range(0, 255))};
      end else if (kind < 95) begin
         if ($urandom_range(0, 1)) begin
            body = {body, BOM_0, BOM_1, BOM_2};
         end
         add_heading(body, 0, 0);
         target = $urandom_range(58, 72);
         while (body.size() < target) body = {body, 8'($urandom_range(8'h20, 8'h7E))};
      end else begin
         body = {body, BOM_0, BOM_1, BOM_2};
         add_heading(body, 0, 8);
      end
      ending = $urandom_range(0, 9);
      if (ending < 7) begin
         if ($urandom_range(0, 1)) body = {body, BYTE_CR};
         body = {body, BYTE_LF};
      end else if (ending < 8 || body.size() == 0) begin
         body = {body, BYTE_LF};
         eof = 1;
      end else begin
         eof = 1;
      end
      put_seq(body, nf, eof);
   endtask

   task automatic put_short_heading(input bit nf);
      byte_list_type seq;
      seq = {BYTE_E7, BYTE_AC, BYTE_AC, 8'($urandom_range(BYTE_DIGIT_0, BYTE_DIGIT_9)),
             BYTE_E7, BYTE_AB, BYTE_A0};
      put_seq(seq, nf, 1);
   endtask

   task automatic wait_idle();
      while (taken_n != queued_n || title_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_skip(input logic [SKIP_W-1:0] value);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      skip_cfg = value;
   endtask

   task automatic put_random_bytes(input int amount);
      int start;
      start = queued_n;
      while (queued_n - start < amount) put_random_line();
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_done)) begin
         req_done = 0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 0;
         end else if (byte_q.size() > 0) begin
            next_byte = byte_q.pop_front();
            req_tdata <= next_byte.data;
            req_tuser <= next_byte.starts_file;
            req_tlast <= next_byte.ends_file;
            req_tvalid <= 1;
            send_gap = pick_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else if (!held && title_q.size() > 0 && byte_q.size() > 30) begin
         held = 1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 0;
      end else if (ready_gap > 0) begin
         ready_gap--;
         rsp_tready <= 0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
         ready_gap = pick_gap();
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         take_byte(req_tdata, req_tuser, req_tlast);
         taken_n++;
         req_done = 1;
      end
   end

   always @(posedge clock) begin
      title_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (title_q.size() == 0) begin
            $error("unexpected title transaction: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            fail_n++;
         end else begin
            want = title_q.pop_front();
            if (rsp_tdata[15:0] !== want.chapter) begin
               $error("chapter_number: expected %0d, got %0d", want.chapter, rsp_tdata[15:0]);
               fail_n++;
            end
            if (rsp_tdata[47:16] !== want.offset) begin
               $error("line_offset: expected %0d, got %0d", want.offset, rsp_tdata[47:16]);
               fail_n++;
            end
            if (rsp_tdata[52:48] !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[52:48]);
               fail_n++;
            end
            if (rsp_tdata[60:53] !== want.glyph) begin
               $error("title_byte: expected %h, got %h", want.glyph, rsp_tdata[60:53]);
               fail_n++;
            end
            if (rsp_tlast !== want.closing) begin
               $error("last_of_title: expected %b, got %b", want.closing, rsp_tlast);
               fail_n++;
            end
            if (rsp_tdata[65:61] !== want.stored) begin
               $error("stored_count: expected %0d, got %0d", want.stored, rsp_tdata[65:61]);
               fail_n++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      if (cycle_n > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      byte_list_type seq;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      write_skip(16'($urandom_range(1, 6)));
      put_random_bytes(40);
      wait_idle();

      // Short BOM line, BOM before a heading, a zero byte, end of file with and without LF.
      write_skip(16'd0);
      seq = {BOM_0, BOM_1, BYTE_CR, BYTE_LF};
      put_seq(seq, 1, 0);
      seq = {BOM_0, BOM_1, BOM_2, BYTE_E7, BYTE_AC, BYTE_AC, 8'h39, BYTE_E7, BYTE_AB,
             BYTE_A0, BYTE_CR, BYTE_LF};
      put_seq(seq, 0, 0);
      seq = {8'h00, BYTE_E7, BYTE_AC, BYTE_AC, BYTE_DIGIT_0, BYTE_E7, BYTE_AB, BYTE_A0};
      put_seq(seq, 0, 1);
      seq = {BYTE_LF};
      put_seq(seq, 0, 1);
      wait_idle();

      // The file goes on past each end of file until the table is full, then a new file starts.
      steady = 1;
      repeat (29) put_short_heading(0);
      put_short_heading(1);
      wait_idle();
      steady = 0;

      if (title_q.size() != 0) begin
         $error("%0d expected title transactions never arrived", title_q.size());
         fail_n++;
      end
      if (fail_n == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
